FILE: hdl/mas_pkg.sv
// Shared types and constants for the matrix add/subtract/multiply unit.
// No dependencies; imported by mas_mac and the top level.
`timescale 1ns / 1ps

package mas_pkg;

    // Sizes fixed by the item fields
    localparam int DATA_W     = 32;   // Q16.16 element
    localparam int IDX_W      = 4;    // row and column fields
    localparam int DIM_W      = 5;    // dimension registers
    localparam int HW_LIMIT   = 16;   // largest dimension the indices can reach
    localparam int MAX_DIM_DEF = 16;  // default store edge

    // Product term is Q32.32 floored to Q32.16: 48 bits; sixteen of them need 4 more, 5 are given
    localparam int TERM_W = 48;
    localparam int ACC_W  = TERM_W + 5;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = DIM_W;

    localparam logic [CFG_IDX_W-1:0] REG_OPERATION = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_ROWS    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_A_COLS    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_COLS    = 8'd3;

    // Operation codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;

    // Request modes
    localparam logic [1:0] MODE_WR_A = 2'd0;
    localparam logic [1:0] MODE_WR_B = 2'd1;
    localparam logic [1:0] MODE_COMP = 2'd2;

    // Control that travels with one term from the memories into the datapath
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic zero;
    } t_term_ctl;

endpackage

FILE: hdl/mas_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/mas_mac.sv
// Term and accumulate datapath: forms a product, sum or difference term from
// two stored elements, accumulates it and saturates the total. Uses mas_pkg.
`timescale 1ns / 1ps

module mas_mac
    import mas_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_term_ctl                i_ctl,
    input  logic [1:0]               i_op,
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [DATA_W-1:0] i_b,
    output logic                     o_done,
    output logic signed [DATA_W-1:0] o_result
);

    logic signed [2*DATA_W-1:0] w_prod;
    logic signed [DATA_W:0]     w_sum;
    logic signed [TERM_W-1:0]   w_term;

    t_term_ctl                  r_ctl;
    logic signed [TERM_W-1:0]   r_term;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_done;

    // Term selection; the product is floored to Q32.16 by dropping 16 bits
    always_comb begin
        w_prod = i_a * i_b;
        if (i_op == OP_SUB) begin
            w_sum = {i_a[DATA_W-1], i_a} - {i_b[DATA_W-1], i_b};
        end else begin
            w_sum = {i_a[DATA_W-1], i_a} + {i_b[DATA_W-1], i_b};
        end
        if (i_ctl.zero) begin
            w_term = '0;
        end else if (i_op == OP_MUL) begin
            w_term = w_prod[2*DATA_W-1:16];
        end else begin
            w_term = {{(TERM_W-DATA_W-1){w_sum[DATA_W]}}, w_sum};
        end
    end

    // Term register, then accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl  <= '0;
            r_done <= 1'b0;
        end else begin
            r_ctl  <= i_ctl;
            r_done <= r_ctl.valid && r_ctl.last;
        end
        if (i_ctl.valid) begin
            r_term <= w_term;
        end
        if (r_ctl.valid) begin
            if (r_ctl.first) begin
                r_acc <= {{(ACC_W-TERM_W){r_term[TERM_W-1]}}, r_term};
            end else begin
                r_acc <= r_acc + {{(ACC_W-TERM_W){r_term[TERM_W-1]}}, r_term};
            end
        end
    end

    // Saturate the total to 32 bits
    always_comb begin
        if (r_acc[ACC_W-1:DATA_W-1] == '0 || r_acc[ACC_W-1:DATA_W-1] == '1) begin
            o_result = r_acc[DATA_W-1:0];
        end else if (r_acc[ACC_W-1]) begin
            o_result = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            o_result = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    assign o_done = r_done;

endmodule

FILE: hdl/matrix_add_sub_multiply_unit.sv
// Top level of the matrix add/subtract/multiply unit: configuration registers,
// request sequencer, the A and B element stores and the output register.
// Depends on mas_pkg, mas_ram and mas_mac.
//
// Channel   Direction  Handshake                     Payload
// in        receive    i_in_valid / o_in_stall       i_mode, i_row, i_col, i_value
// out       send       o_out_valid / i_out_stall     o_out_row, o_out_col, o_result, o_last
// cfg       receive    i_cfg_we (no wait)            i_cfg_index, i_cfg_data
//
// A compute request reads one A and one B element per cycle while it walks a
// column, through the single read port of each store: a product column reads
// the effective a_cols (at least one) terms, a sum or difference column one
// term. o_in_stall is high from a compute request until its last column sits
// in the output register. Reset is synchronous; the stores need no clearing.
// i_out_stall only holds the sequencer before the next column's result is
// loaded.
`timescale 1ns / 1ps

module matrix_add_sub_multiply_unit
    import mas_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_mode,
    input  logic [IDX_W-1:0]         i_row,
    input  logic [IDX_W-1:0]         i_col,
    input  logic signed [DATA_W-1:0] i_value,
    // result channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [IDX_W-1:0]         o_out_row,
    output logic [IDX_W-1:0]         o_out_col,
    output logic signed [DATA_W-1:0] o_result,
    output logic                     o_last,
    // configuration
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int LIM   = (MAX_DIM < HW_LIMIT) ? MAX_DIM : HW_LIMIT;
    localparam logic [DIM_W-1:0]   LIM_D  = DIM_W'(LIM);
    localparam logic [IDX_W+2:0]   DIM_CMP = (IDX_W+3)'(MAX_DIM);
    localparam logic [AW-1:0]      DIM_A  = AW'(MAX_DIM);

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_DRAIN} t_state;

    t_state              r_state;
    logic [1:0]          r_operation;
    logic [DIM_W-1:0]    r_a_rows;
    logic [DIM_W-1:0]    r_a_cols;
    logic [DIM_W-1:0]    r_b_cols;

    logic [1:0]          r_op;
    logic [IDX_W-1:0]    r_row;
    logic [IDX_W-1:0]    r_col;
    logic [IDX_W-1:0]    r_k;
    logic [DIM_W-1:0]    r_ncols;
    logic [DIM_W-1:0]    r_nterm;
    logic                r_zero;
    t_term_ctl           r_issue;
    logic                r_res_ready;

    logic                r_out_valid;
    logic [IDX_W-1:0]    r_out_row;
    logic [IDX_W-1:0]    r_out_col;
    logic [DATA_W-1:0]   r_out_result;
    logic                r_out_last;

    logic                w_in_acc;
    logic                w_out_acc;
    logic [DIM_W-1:0]    w_rows;
    logic [DIM_W-1:0]    w_inner;
    logic [DIM_W-1:0]    w_ncols;
    logic                w_comp_ok;
    logic                w_wr_ok;
    logic [AW-1:0]       w_waddr;
    logic [AW-1:0]       w_raddr_a;
    logic [AW-1:0]       w_raddr_b;
    logic                w_term_last;
    logic                w_col_last;
    logic                w_load;
    logic [DATA_W-1:0]   w_rdata_a;
    logic [DATA_W-1:0]   w_rdata_b;
    logic                w_mac_done;
    logic [DATA_W-1:0]   w_mac_result;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        eff_dim = (d > LIM_D) ? LIM_D : d;
    endfunction

    // Handshakes and request decode
    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = r_out_valid && !i_out_stall;
    assign w_rows    = eff_dim(r_a_rows);
    assign w_inner   = eff_dim(r_a_cols);
    assign w_ncols   = (r_operation == OP_MUL) ? eff_dim(r_b_cols) : w_inner;
    assign w_comp_ok = (i_mode == MODE_COMP) && (r_operation != 2'd3)
                       && ({1'b0, i_row} < w_rows) && (w_ncols != '0);
    assign w_wr_ok   = w_in_acc && (i_mode == MODE_WR_A || i_mode == MODE_WR_B)
                       && ({3'b000, i_row} < DIM_CMP) && ({3'b000, i_col} < DIM_CMP);
    assign w_waddr   = AW'(i_row) * DIM_A + AW'(i_col);

    // Store addresses: product walks k down A's row and B's column
    always_comb begin
        if (r_op == OP_MUL) begin
            w_raddr_a = AW'(r_row) * DIM_A + AW'(r_k);
            w_raddr_b = AW'(r_k) * DIM_A + AW'(r_col);
        end else begin
            w_raddr_a = AW'(r_row) * DIM_A + AW'(r_col);
            w_raddr_b = w_raddr_a;
        end
    end

    assign w_term_last = ({1'b0, r_k} == r_nterm - 1'b1);
    assign w_col_last  = ({1'b0, r_col} == r_ncols - 1'b1);
    assign w_load      = (r_state == S_DRAIN) && r_res_ready
                         && (!r_out_valid || w_out_acc);

    // Sequencer, configuration registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_operation <= OP_MUL;
            r_a_rows    <= DIM_W'(16);
            r_a_cols    <= DIM_W'(16);
            r_b_cols    <= DIM_W'(16);
            r_issue     <= '0;
            r_res_ready <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_OPERATION: r_operation <= i_cfg_data[1:0];
                    REG_A_ROWS:    r_a_rows    <= i_cfg_data;
                    REG_A_COLS:    r_a_cols    <= i_cfg_data;
                    REG_B_COLS:    r_b_cols    <= i_cfg_data;
                    default: ;
                endcase
            end
            // One term goes out per cycle of the issue state.
            if (r_state == S_ISSUE) begin
                r_issue <= '{valid: 1'b1, first: (r_k == '0), last: w_term_last,
                             zero: r_zero};
            end else begin
                r_issue <= '0;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
            if (w_mac_done) begin
                r_res_ready <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && w_comp_ok) begin
                        r_op    <= r_operation;
                        r_row   <= i_row;
                        r_col   <= '0;
                        r_k     <= '0;
                        r_ncols <= w_ncols;
                        if (r_operation == OP_MUL && w_inner != '0) begin
                            r_nterm <= w_inner;
                        end else begin
                            r_nterm <= DIM_W'(1);
                        end
                        r_zero  <= (r_operation == OP_MUL) && (w_inner == '0);
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    if (w_term_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (w_load) begin
                        r_res_ready  <= 1'b0;
                        r_out_row    <= r_row;
                        r_out_col    <= r_col;
                        r_out_result <= w_mac_result;
                        r_out_last   <= w_col_last;
                        r_k          <= '0;
                        if (w_col_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_col   <= r_col + 1'b1;
                            r_state <= S_ISSUE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Element stores
    mas_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_we    (w_wr_ok && i_mode == MODE_WR_A),
        .i_waddr (w_waddr),
        .i_wdata (i_value),
        .i_raddr (w_raddr_a),
        .o_rdata (w_rdata_a)
    );

    mas_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_store_b (
        .i_clk   (i_clk),
        .i_we    (w_wr_ok && i_mode == MODE_WR_B),
        .i_waddr (w_waddr),
        .i_wdata (i_value),
        .i_raddr (w_raddr_b),
        .o_rdata (w_rdata_b)
    );

    // Term and accumulate datapath
    mas_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_issue),
        .i_op     (r_op),
        .i_a      (w_rdata_a),
        .i_b      (w_rdata_b),
        .o_done   (w_mac_done),
        .o_result (w_mac_result)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_result    = r_out_result;
    assign o_last      = r_out_last;

    // A finished column never lands on top of a pending one.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mac_done |-> !r_res_ready)
        else $error("accumulator finished while previous result still pending");

    // Nothing is left in flight once the sequencer is idle again.
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_res_ready && !r_issue.valid))
        else $error("sequencer idle with work in flight");

    // Store reads are issued only while a compute request is being walked.
    a_issue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issue.valid |-> $past(r_state == S_ISSUE))
        else $error("term issued outside the issue state");

    // Loading the output register follows a completed accumulation.
    a_load_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> r_res_ready && !w_mac_done)
        else $error("result loaded without a finished accumulation");

endmodule
